/* rtl/core/mihist_pkg.sv */
// Package: shared constants, types and helpers for the instruction mix histogram.
`timescale 1ns / 1ps
`default_nettype none

package mihist_pkg;

   localparam int NUM_BINS    = 128;
   localparam int COUNT_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int HALF_BINS   = NUM_BINS / 2;
   localparam int HALF_AW     = $clog2(HALF_BINS);
   localparam int BIN_W       = $clog2(NUM_BINS);

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [HALF_AW-1:0]     half_addr_type;

   localparam logic [31:0] WORD_ERET = 32'h4200_0018;

   // opcodes that need a second look
   localparam logic [5:0] OP_SPECIAL  = 6'd0;
   localparam logic [5:0] OP_REGIMM   = 6'd1;
   localparam logic [5:0] OP_COP0     = 6'd16;
   localparam logic [5:0] OP_COP1     = 6'd17;
   localparam logic [5:0] OP_COP2     = 6'd18;
   localparam logic [5:0] OP_SPECIAL2 = 6'd28;

   localparam logic [4:0] RS_ZERO = 5'd0;
   localparam logic [4:0] RS_BGEZ = 5'd1;
   localparam logic [4:0] RS_MT   = 5'd4;

   localparam logic [5:0] FN_MADD  = 6'd0;
   localparam logic [5:0] FN_MADDU = 6'd1;
   localparam logic [5:0] FN_MUL   = 6'd2;

   localparam logic [5:0] BIN_BGEZ    = 6'd56;
   localparam logic [5:0] BIN_MFC0    = 6'd57;
   localparam logic [5:0] BIN_MTC0    = 6'd58;
   localparam logic [5:0] BIN_MTC1    = 6'd59;
   localparam logic [5:0] BIN_MTC2    = 6'd60;
   localparam logic [5:0] BIN_MADD    = 6'd61;
   localparam logic [5:0] BIN_MADDU   = 6'd62;
   localparam logic [5:0] BIN_UNKNOWN = 6'd63;

   localparam logic FUNC_CLASSIFY = 1'b0;
   localparam logic FUNC_READ     = 1'b1;

   typedef struct packed {
      logic [HALF_AW-1:0] prim;
      logic               rtype;
      logic [HALF_AW-1:0] funct;
   } class_type;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      if (v == {COUNT_WIDTH{1'b1}}) begin
         r = v;
      end else begin
         r = COUNT_WIDTH'(v + 1'b1);
      end
      return r;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] to_out(input count_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/mihist_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mihist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/mihist_classify.sv */
// Opcode decoder: maps an instruction word to its primary and funct bins.
`timescale 1ns / 1ps
`default_nettype none

module mihist_classify
   import mihist_pkg::*;
(
   input  wire logic [31:0] instr_word,
   output class_type        cls
);

   logic [5:0] op;
   logic [4:0] rs;
   logic [5:0] fn;
   logic [5:0] prim;

   assign op = instr_word[31:26];
   assign rs = instr_word[25:21];
   assign fn = instr_word[5:0];

   always_comb begin
      case (op)
         OP_REGIMM: begin
            if (rs == RS_ZERO)      prim = op;
            else if (rs == RS_BGEZ) prim = BIN_BGEZ;
            else                    prim = BIN_UNKNOWN;
         end
         OP_COP0: begin
            if (instr_word == WORD_ERET) prim = op;
            else if (rs == RS_ZERO)      prim = BIN_MFC0;
            else if (rs == RS_MT)        prim = BIN_MTC0;
            else                         prim = BIN_UNKNOWN;
         end
         OP_COP1: begin
            if (rs == RS_ZERO)    prim = op;
            else if (rs == RS_MT) prim = BIN_MTC1;
            else                  prim = BIN_UNKNOWN;
         end
         OP_COP2: begin
            if (rs == RS_ZERO)    prim = op;
            else if (rs == RS_MT) prim = BIN_MTC2;
            else                  prim = BIN_UNKNOWN;
         end
         OP_SPECIAL2: begin
            if (fn == FN_MUL)        prim = op;
            else if (fn == FN_MADD)  prim = BIN_MADD;
            else if (fn == FN_MADDU) prim = BIN_MADDU;
            else                     prim = BIN_UNKNOWN;
         end
         default: begin
            prim = op;
         end
      endcase
   end

   assign cls.prim  = prim;
   assign cls.rtype = (op == OP_SPECIAL);
   assign cls.funct = fn;

endmodule

`default_nettype wire

/* rtl/core/mips_instruction_mix_histogram.sv */
// Top level: instruction mix histogram with opcode and funct counters in two RAMs.
// A result is registered when the update state fires, which waits while an unaccepted response is held.
// Requests: RAM read on accept, then saturating write back; no new request is taken before that write.
// The read-modify-write of each request ends before the next read is issued.
// Reset: a clearing pass zeroes all 64 addresses of both RAMs; req_ready stays low meanwhile.
// The total counter and the response valid flag clear at once.
`timescale 1ns / 1ps
`default_nettype none

module mips_instruction_mix_histogram
   import mihist_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [31:0] req_instr_word,
   input  wire logic [6:0]  req_read_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_primary_bin,
   output logic             rsp_secondary_valid,
   output logic [6:0]       rsp_secondary_bin,
   output logic [31:0]      rsp_bin_count,
   output logic [31:0]      rsp_total_count
);

   state_type     state_ff, state_in;
   half_addr_type clr_cnt_ff, clr_cnt_in;
   count_type     total_ff, total_in;

   logic          op_read_ff, op_read_in;
   logic          rtype_ff, rtype_in;
   logic          sel_hi_ff, sel_hi_in;
   half_addr_type addr_p_ff, addr_p_in;
   half_addr_type addr_f_ff, addr_f_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    prim_bin_ff, prim_bin_in;
   logic          sec_valid_ff, sec_valid_in;
   logic [6:0]    sec_bin_ff, sec_bin_in;
   logic [31:0]   bin_count_ff, bin_count_in;
   logic [31:0]   total_out_ff, total_out_in;

   class_type     cls;
   logic          accept, fire;
   half_addr_type rd_addr_p, rd_addr_f;
   count_type     rd_data_p, rd_data_f;
   logic          we_p, we_f;
   half_addr_type wa_p, wa_f;
   count_type     wd_p, wd_f;

   mihist_classify u_classify (
      .instr_word (req_instr_word),
      .cls        (cls)
   );

   // bins 0..63: opcode counters
   mihist_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HALF_BINS)) u_prim_ram (
      .clock   (clock),
      .wr_en   (we_p),
      .wr_addr (wa_p),
      .wr_data (wd_p),
      .rd_addr (rd_addr_p),
      .rd_data (rd_data_p)
   );

   // bins 64..127: R-type funct counters
   mihist_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HALF_BINS)) u_funct_ram (
      .clock   (clock),
      .wr_en   (we_f),
      .wr_addr (wa_f),
      .wr_data (wd_f),
      .rd_addr (rd_addr_f),
      .rd_data (rd_data_f)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   // latch the decoded request on accept
   always_comb begin
      op_read_in = op_read_ff;
      rtype_in   = rtype_ff;
      sel_hi_in  = sel_hi_ff;
      addr_p_in  = addr_p_ff;
      addr_f_in  = addr_f_ff;
      if (accept) begin
         if (req_func == FUNC_READ) begin
            op_read_in = 1'b1;
            rtype_in   = 1'b0;
            sel_hi_in  = req_read_index[BIN_W-1];
            addr_p_in  = req_read_index[HALF_AW-1:0];
            addr_f_in  = req_read_index[HALF_AW-1:0];
         end else begin
            op_read_in = 1'b0;
            rtype_in   = cls.rtype;
            sel_hi_in  = 1'b0;
            addr_p_in  = cls.prim;
            addr_f_in  = cls.funct;
         end
      end
   end

   // read addresses: straight from the request while idle, held while stalled
   assign rd_addr_p = (state_ff == ST_IDLE) ? addr_p_in : addr_p_ff;
   assign rd_addr_f = (state_ff == ST_IDLE) ? addr_f_in : addr_f_ff;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         we_p = 1'b1;
         we_f = 1'b1;
         wa_p = clr_cnt_ff;
         wa_f = clr_cnt_ff;
         wd_p = '0;
         wd_f = '0;
      end else begin
         we_p = fire && !op_read_ff;
         we_f = fire && !op_read_ff && rtype_ff;
         wa_p = addr_p_ff;
         wa_f = addr_f_ff;
         wd_p = sat_inc(rd_data_p);
         wd_f = sat_inc(rd_data_f);
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == half_addr_type'(HALF_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (fire) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      prim_bin_in  = prim_bin_ff;
      sec_valid_in = sec_valid_ff;
      sec_bin_in   = sec_bin_ff;
      bin_count_in = bin_count_ff;
      total_out_in = total_out_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (op_read_ff) begin
            prim_bin_in  = '0;
            sec_valid_in = 1'b0;
            sec_bin_in   = '0;
            bin_count_in = to_out(sel_hi_ff ? rd_data_f : rd_data_p);
            total_out_in = to_out(total_ff);
         end else begin
            total_in     = sat_inc(total_ff);
            prim_bin_in  = {1'b0, addr_p_ff};
            sec_valid_in = rtype_ff;
            sec_bin_in   = rtype_ff ? {1'b1, addr_f_ff} : 7'd0;
            bin_count_in = '0;
            total_out_in = to_out(sat_inc(total_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_read_ff   <= op_read_in;
      rtype_ff     <= rtype_in;
      sel_hi_ff    <= sel_hi_in;
      addr_p_ff    <= addr_p_in;
      addr_f_ff    <= addr_f_in;
      prim_bin_ff  <= prim_bin_in;
      sec_valid_ff <= sec_valid_in;
      sec_bin_ff   <= sec_bin_in;
      bin_count_ff <= bin_count_in;
      total_out_ff <= total_out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_primary_bin     = prim_bin_ff;
   assign rsp_secondary_valid = sec_valid_ff;
   assign rsp_secondary_bin   = sec_bin_ff;
   assign rsp_bin_count       = bin_count_ff;
   assign rsp_total_count     = total_out_ff;

endmodule

`default_nettype wire

/* rtl/core/mihist_checker.sv */
// Port-level checker for the instruction mix histogram, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mihist_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [6:0]  rsp_primary_bin,
   input wire logic        rsp_secondary_valid,
   input wire logic [6:0]  rsp_secondary_bin,
   input wire logic [31:0] rsp_bin_count,
   input wire logic [31:0] rsp_total_count
);

   // one request in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in flight");

   // funct bin only comes with the R-type opcode bin
   a_secondary_rtype: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_secondary_valid |-> rsp_primary_bin == 7'd0 && rsp_secondary_bin[6])
      else $error("funct bin reported for a non R-type word");

   // a nonzero bin count only on reads, which carry no bins
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bin_count != 32'd0 |-> rsp_primary_bin == 7'd0 && !rsp_secondary_valid)
      else $error("bin count shown on a classify result");

   a_primary_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_primary_bin[6])
      else $error("primary bin outside opcode range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_count))
      else $error("stalled response changed");

endmodule

bind mips_instruction_mix_histogram mihist_checker u_mihist_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_primary_bin     (rsp_primary_bin),
   .rsp_secondary_valid (rsp_secondary_valid),
   .rsp_secondary_bin   (rsp_secondary_bin),
   .rsp_bin_count       (rsp_bin_count),
   .rsp_total_count     (rsp_total_count)
);

`default_nettype wire

/* test/tb_mips_instruction_mix_histogram.sv */
// Testbench for the instruction mix histogram: predicts each response and checks it in order.
`timescale 1ns / 1ps

module tb_mips_instruction_mix_histogram;
   import mihist_pkg::*;

   localparam logic [6:0] FUNCT_BASE = 7'd64;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         RANDOM_ITEMS = 650;

   typedef struct {
      logic        func;
      logic [31:0] word;
      logic [6:0]  idx;
      logic        hold;    // wait for all responses before presenting this request
   } instr_req_type;

   typedef struct {
      logic [6:0]  prim;
      logic        sval;
      logic [6:0]  sbin;
      logic [31:0] bcount;
      logic [31:0] total;
   } hist_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_CLASSIFY;
   logic [31:0] req_instr_word = '0;
   logic [6:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_primary_bin;
   logic        rsp_secondary_valid;
   logic [6:0]  rsp_secondary_bin;
   logic [31:0] rsp_bin_count;
   logic [31:0] rsp_total_count;

   instr_req_type instr_req_q[$];
   hist_rsp_type  hist_rsp_q[$];
   logic [31:0]   bin_model[NUM_BINS];
   logic [31:0]   total_model;
   int            n_accepted = 0;
   int            n_checked = 0;
   int            n_errors = 0;
   int            stall_cycles = 0;

   mips_instruction_mix_histogram dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_instr_word      (req_instr_word),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_primary_bin     (rsp_primary_bin),
      .rsp_secondary_valid (rsp_secondary_valid),
      .rsp_secondary_bin   (rsp_secondary_bin),
      .rsp_bin_count       (rsp_bin_count),
      .rsp_total_count     (rsp_total_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] classify_opcode(input logic [31:0] w);
      logic [5:0] op;
      logic [4:0] rs;
      logic [5:0] fn;
      logic [5:0] b;
      op = w[31:26];
      rs = w[25:21];
      fn = w[5:0];
      b  = op;
      case (op)
         OP_REGIMM: begin
            if (rs == RS_ZERO) b = op;
            else if (rs == RS_BGEZ) b = BIN_BGEZ;
            else b = BIN_UNKNOWN;
         end
         OP_COP0: begin
            if (w == WORD_ERET) b = op;
            else if (rs == RS_ZERO) b = BIN_MFC0;
            else if (rs == RS_MT) b = BIN_MTC0;
            else b = BIN_UNKNOWN;
         end
         OP_COP1: begin
            if (rs == RS_ZERO) b = op;
            else if (rs == RS_MT) b = BIN_MTC1;
            else b = BIN_UNKNOWN;
         end
         OP_COP2: begin
            if (rs == RS_ZERO) b = op;
            else if (rs == RS_MT) b = BIN_MTC2;
            else b = BIN_UNKNOWN;
         end
         OP_SPECIAL2: begin
            if (fn == FN_MUL) b = op;
            else if (fn == FN_MADD) b = BIN_MADD;
            else if (fn == FN_MADDU) b = BIN_MADDU;
            else b = BIN_UNKNOWN;
         end
         default: b = op;
      endcase
      return {1'b0, b};
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic histogram_update(input logic func, input logic [31:0] word,
                                   input logic [6:0] idx, output hist_rsp_type r);
      logic [6:0] p;
      r = '{prim: '0, sval: 1'b0, sbin: '0, bcount: '0, total: '0};
      if (func == FUNC_CLASSIFY) begin
         p = classify_opcode(word);
         r.prim = p;
         bin_model[p] = bump(bin_model[p]);
         if (p == {1'b0, OP_SPECIAL}) begin
            r.sval = 1'b1;
            r.sbin = FUNCT_BASE + {1'b0, word[5:0]};
            bin_model[r.sbin] = bump(bin_model[r.sbin]);
         end
         total_model = bump(total_model);
      end else begin
         r.bcount = bin_model[idx];
      end
      r.total = total_model;
   endtask

   task automatic add_req(input logic func, input logic [31:0] word,
                          input logic [6:0] idx, input logic hold);
      instr_req_type it;
      it.func = func;
      it.word = word;
      it.idx  = idx;
      it.hold = hold;
      instr_req_q.push_back(it);
   endtask

   // 45 percent of words use shared opcodes with the rs / funct values that steer them
   function automatic logic [31:0] gen_word();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 99) < 45) begin
         case ($urandom_range(0, 5))
            0: w[31:26] = OP_SPECIAL;
            1: w[31:26] = OP_REGIMM;
            2: w[31:26] = OP_COP0;
            3: w[31:26] = OP_COP1;
            4: w[31:26] = OP_COP2;
            default: w[31:26] = OP_SPECIAL2;
         endcase
         case ($urandom_range(0, 3))
            0: w[25:21] = RS_ZERO;
            1: w[25:21] = RS_BGEZ;
            2: w[25:21] = RS_MT;
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0: w[5:0] = FN_MADD;
            1: w[5:0] = FN_MADDU;
            2: w[5:0] = FN_MUL;
            default: ;
         endcase
         if ($urandom_range(0, 19) == 0) w = WORD_ERET;
      end
      return w;
   endfunction

   // driver
   always @(posedge clock) begin : drive_proc
      logic          fire;
      logic          gap;
      hist_rsp_type  r;
      instr_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            histogram_update(req_func, req_instr_word, req_read_index, r);
            hist_rsp_q.push_back(r);
            n_accepted++;
         end
         if (!req_valid || fire) begin
            gap = !(n_accepted >= 300 && n_accepted < 420) && ($urandom_range(0, 99) < 17);
            if (instr_req_q.size() > 0 && !gap &&
                !(instr_req_q[0].hold && hist_rsp_q.size() > 0)) begin
               it = instr_req_q.pop_front();
               req_func       <= it.func;
               req_instr_word <= it.word;
               req_read_index <= it.idx;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor_proc
      hist_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hist_rsp_q.size() == 0) begin
               $error("unexpected response: primary_bin %0d total_count %0d",
                      rsp_primary_bin, rsp_total_count);
               n_errors++;
            end else begin
               e = hist_rsp_q.pop_front();
               if (rsp_primary_bin !== e.prim) begin
                  $error("primary_bin: expected %0d, got %0d", e.prim, rsp_primary_bin);
                  n_errors++;
               end
               if (rsp_secondary_valid !== e.sval) begin
                  $error("secondary_valid: expected %0d, got %0d", e.sval,
                         rsp_secondary_valid);
                  n_errors++;
               end
               if (rsp_secondary_bin !== e.sbin) begin
                  $error("secondary_bin: expected %0d, got %0d", e.sbin, rsp_secondary_bin);
                  n_errors++;
               end
               if (rsp_bin_count !== e.bcount) begin
                  $error("bin_count: expected %0d, got %0d", e.bcount, rsp_bin_count);
                  n_errors++;
               end
               if (rsp_total_count !== e.total) begin
                  $error("total_count: expected %0d, got %0d", e.total, rsp_total_count);
                  n_errors++;
               end
            end
            n_checked++;
         end
         rsp_ready <= (n_checked >= 300 && n_checked < 420) ||
                      ($urandom_range(0, 99) >= 17);
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_BINS; i++) bin_model[i] = '0;
      total_model = '0;

      // directed: empty bins, every shared-opcode split, funct extremes
      add_req(FUNC_READ,     32'hFFFF_FFFF, 7'd0,   1'b0);
      add_req(FUNC_READ,     32'h0000_0000, 7'd127, 1'b0);
      add_req(FUNC_CLASSIFY, 32'h0000_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h0000_003F, 7'd127, 1'b0);
      add_req(FUNC_CLASSIFY, 32'hFFFF_FFFF, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h0400_1234, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h0420_1234, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h07E0_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, WORD_ERET,     7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4200_0019, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4001_7800, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4081_7800, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4040_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4400_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4480_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4420_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4800_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4880_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h4BE0_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h7000_0002, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h7000_0000, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h7000_0001, 7'd0,   1'b0);
      add_req(FUNC_CLASSIFY, 32'h7000_003F, 7'd0,   1'b0);
      add_req(FUNC_READ,     32'h0000_0000, 7'd63,  1'b0);
      add_req(FUNC_READ,     32'h0000_0000, 7'd64,  1'b0);
      add_req(FUNC_READ,     32'h0000_0000, 7'd127, 1'b0);
      add_req(FUNC_READ,     32'h0000_0000, 7'd56,  1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_req(($urandom_range(0, 99) < 70) ? FUNC_CLASSIFY : FUNC_READ,
                 gen_word(), 7'($urandom_range(0, 127)), (i == 150 || i == 500));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver's queue and valid agree
      while (instr_req_q.size() > 0 || req_valid || hist_rsp_q.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);

      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
